/* hdl/cbc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cbc_pkg;

    localparam int ROM_PORT_W = 7;
    localparam int RAM_PORT_W = 2;

    localparam logic [1:0] CART_ROM_ONLY    = 2'd0;
    localparam logic [1:0] CART_BANKED      = 2'd1;
    localparam logic [1:0] CART_UNSUPPORTED = 2'd2;

    localparam logic [1:0] TARGET_NONE = 2'd0;
    localparam logic [1:0] TARGET_ROM  = 2'd1;
    localparam logic [1:0] TARGET_RAM  = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // control register select, bus_address[14:13] of a write below 0x8000
    localparam logic [1:0] REG_RAM_ENABLE = 2'd0;
    localparam logic [1:0] REG_ROM_LOW    = 2'd1;
    localparam logic [1:0] REG_ROM_UPPER  = 2'd2;
    localparam logic [1:0] REG_MODE       = 2'd3;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    typedef struct packed {
        logic        operation;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } bus_beat_t;

    typedef struct packed {
        logic                  ram_enabled;
        logic [ROM_PORT_W-1:0] rom_bank;
        logic [RAM_PORT_W-1:0] ram_bank;
    } bank_state_t;

endpackage
`default_nettype wire

/* hdl/cbc_bank_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
module cbc_bank_regs
    import cbc_pkg::*;
#(
    parameter int ROM_BANK_BITS = 7,
    parameter int RAM_BANK_BITS = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [1:0]  cart_kind,
    input  wire bus_beat_t   beat,
    input  wire logic        commit,
    output bank_state_t      state_next
);

    logic [ROM_BANK_BITS-1:0] rom_bank_reg;
    logic [ROM_BANK_BITS-1:0] rom_bank_next;
    logic [RAM_BANK_BITS-1:0] ram_bank_reg;
    logic [RAM_BANK_BITS-1:0] ram_bank_next;
    logic                     ram_enable_reg;
    logic                     ram_enable_next;
    logic                     rom_mode_reg;
    logic                     rom_mode_next;

    logic [ROM_PORT_W-1:0]    rom_full;
    logic [ROM_PORT_W-1:0]    rom_cand;
    logic [ROM_BANK_BITS-1:0] rom_masked;
    logic                     ctrl_write;

    always_comb
    begin
        rom_full        = ROM_PORT_W'(rom_bank_reg);
        rom_cand        = rom_full;
        rom_bank_next   = rom_bank_reg;
        ram_bank_next   = ram_bank_reg;
        ram_enable_next = ram_enable_reg;
        rom_mode_next   = rom_mode_reg;
        ctrl_write      = (beat.operation == OP_WRITE) && !beat.bus_address[15]
                          && (cart_kind == CART_BANKED);
        rom_masked      = rom_bank_reg;

        if (ctrl_write)
        begin
            case (beat.bus_address[14:13])
                REG_RAM_ENABLE:
                begin
                    ram_enable_next = (beat.write_data[3:0] == RAM_ENABLE_KEY);
                end
                REG_ROM_LOW:
                begin
                    rom_cand      = {rom_full[6:5], beat.write_data[4:0]};
                    rom_masked    = rom_cand[ROM_BANK_BITS-1:0];
                    rom_bank_next = (rom_masked == '0) ? ROM_BANK_BITS'(1) : rom_masked;
                end
                REG_ROM_UPPER:
                begin
                    if (rom_mode_reg)
                    begin
                        rom_cand      = {beat.write_data[1:0], rom_full[4:0]};
                        rom_masked    = rom_cand[ROM_BANK_BITS-1:0];
                        rom_bank_next = (rom_masked == '0) ? ROM_BANK_BITS'(1) : rom_masked;
                    end
                    else
                    begin
                        ram_bank_next = beat.write_data[RAM_BANK_BITS-1:0];
                    end
                end
                REG_MODE:
                begin
                    rom_mode_next = !beat.write_data[0];
                    if (!beat.write_data[0])
                    begin
                        ram_bank_next = '0;
                    end
                end
                default:
                begin
                    rom_mode_next = rom_mode_reg;
                end
            endcase
        end

        state_next.ram_enabled = ram_enable_next;
        state_next.rom_bank    = ROM_PORT_W'(rom_bank_next);
        state_next.ram_bank    = RAM_PORT_W'(ram_bank_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg   <= ROM_BANK_BITS'(1);
            ram_bank_reg   <= '0;
            ram_enable_reg <= 1'b0;
            rom_mode_reg   <= 1'b1;
        end
        else if (commit)
        begin
            rom_bank_reg   <= rom_bank_next;
            ram_bank_reg   <= ram_bank_next;
            ram_enable_reg <= ram_enable_next;
            rom_mode_reg   <= rom_mode_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/cartridge_bank_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// Cartridge bank controller: one result beat per bus access beat, one beat per cycle
// sustained while out_stall stays low. An accepted access sits in an input register;
// when it moves on, the bank registers are updated (writes below 0x8000 on a banked
// cartridge) and the translated ROM or RAM address plus the resulting bank state land
// in the output register. The input register frees up as soon as the output register
// is taken or empty, which is what sets the one-beat-per-cycle rate.
// cart_kind may only be written while no access is in flight.
module cartridge_bank_controller
    import cbc_pkg::*;
#(
    parameter int ROM_BANK_BITS = 7,
    parameter int RAM_BANK_BITS = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_data,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [15:0] bus_address,
    input  wire logic [7:0]  write_data,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       target,
    output logic [20:0]      physical_address,
    output logic             ram_enabled,
    output logic [6:0]       rom_bank,
    output logic [1:0]       ram_bank
);

    logic [1:0]  cart_kind_reg;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    bus_beat_t   s1_beat_reg;
    logic        s1_move;
    logic        in_accept;
    logic        commit;

    bank_state_t state_next;
    logic [1:0]  target_next;
    logic [20:0] phys_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  target_reg;
    logic [20:0] phys_reg;
    bank_state_t state_reg;

    assign s1_move        = !out_valid_reg || !out_stall;
    assign in_stall       = s1_valid_reg && !s1_move;
    assign in_accept      = in_valid && !in_stall;
    assign commit         = s1_valid_reg && s1_move;
    assign s1_valid_next  = in_accept || (s1_valid_reg && !s1_move);
    assign out_valid_next = commit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cart_kind_reg <= CART_BANKED;
        end
        else if (cfg_wr_en)
        begin
            cart_kind_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_beat_reg.operation   <= operation;
            s1_beat_reg.bus_address <= bus_address;
            s1_beat_reg.write_data  <= write_data;
        end
    end

    cbc_bank_regs #(
        .ROM_BANK_BITS (ROM_BANK_BITS),
        .RAM_BANK_BITS (RAM_BANK_BITS)
    ) u_bank_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cart_kind  (cart_kind_reg),
        .beat       (s1_beat_reg),
        .commit     (commit),
        .state_next (state_next)
    );

    // reads leave the bank state alone, so the post-access state is also the one to use
    always_comb
    begin
        target_next = TARGET_NONE;
        phys_next   = '0;
        if (s1_beat_reg.operation == OP_READ)
        begin
            if (s1_beat_reg.bus_address[15:14] == 2'b01)
            begin
                target_next = TARGET_ROM;
                phys_next   = {state_next.rom_bank, s1_beat_reg.bus_address[13:0]};
            end
            else if (s1_beat_reg.bus_address[15:13] == 3'b101)
            begin
                target_next = TARGET_RAM;
                phys_next   = 21'({state_next.ram_bank, s1_beat_reg.bus_address[12:0]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            target_reg <= target_next;
            phys_reg   <= phys_next;
            state_reg  <= state_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign target           = target_reg;
    assign physical_address = phys_reg;
    assign ram_enabled      = state_reg.ram_enabled;
    assign rom_bank         = state_reg.rom_bank;
    assign ram_bank         = state_reg.ram_bank;

`ifndef SYNTHESIS
    a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rom_bank != 7'd0))
        else $error("rom bank zero on output beat");

    a_rom_phys_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (target == TARGET_ROM)) |-> (physical_address[20:14] == rom_bank))
        else $error("rom physical address does not match bank");

    a_write_no_target: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (s1_beat_reg.operation == OP_WRITE)) |=> (target == TARGET_NONE))
        else $error("write beat produced a translated target");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(physical_address)))
        else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;
    import cbc_pkg::*;

    localparam logic [1:0] CART_KIND_RESERVED = 2'd3;
    localparam int NUM_DIRECTED = 26;
    localparam int NUM_PHASES = 8;
    localparam int ACCESSES_PER_PHASE = 240;
    localparam int CALM_PHASE = 4;
    localparam int DRAIN_PHASE = 6;
    localparam int DRAIN_AT = 120;
    localparam int HOLD_AT = 600;
    localparam int HOLD_CYCLES = 64;
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_PCT = 29;

    typedef struct packed {
        logic [1:0]  target;
        logic [20:0] phys;
        logic        ram_en;
        logic [6:0]  rom;
        logic [1:0]  ram;
    } translation_t;

    typedef struct packed {
        logic [1:0]   kind;
        logic         op;
        logic [15:0]  addr;
        logic [7:0]   data;
        logic         typed;
        translation_t want;
    } access_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_data = 2'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        operation = OP_WRITE;
    logic [15:0] bus_address = 16'h0000;
    logic [7:0]  write_data = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  target;
    logic [20:0] physical_address;
    logic        ram_enabled;
    logic [6:0]  rom_bank;
    logic [1:0]  ram_bank;

    // predicted controller state
    logic [1:0] cur_kind = CART_BANKED;
    logic [6:0] cur_rom = 7'd1;
    logic [1:0] cur_ram = 2'd0;
    logic       cur_ram_en = 1'b0;
    logic       cur_rom_mode = 1'b1;

    translation_t pending_translations[$];
    translation_t want;
    access_row_t  directed_rows [NUM_DIRECTED];
    int           err_count = 0;
    int           beats_seen = 0;
    logic         calm = 1'b0;
    logic         hold_done = 1'b0;

    cartridge_bank_controller DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .bus_address      (bus_address),
        .write_data       (write_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .target           (target),
        .physical_address (physical_address),
        .ram_enabled      (ram_enabled),
        .rom_bank         (rom_bank),
        .ram_bank         (ram_bank)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic translation_t translate_access(input logic op, input logic [15:0] addr,
                                                      input logic [7:0] data);
        translation_t res;
        res = '0;
        if (op == OP_WRITE) begin
            if (addr < 16'h8000 && cur_kind == CART_BANKED) begin
                case (addr[14:13])
                    REG_RAM_ENABLE: cur_ram_en = (data[3:0] == RAM_ENABLE_KEY);
                    REG_ROM_LOW:
                    begin
                        cur_rom = {cur_rom[6:5], data[4:0]};
                        if (cur_rom == 7'd0)
                            cur_rom = 7'd1;
                    end
                    REG_ROM_UPPER:
                    begin
                        if (cur_rom_mode) begin
                            cur_rom = {data[1:0], cur_rom[4:0]};
                            if (cur_rom == 7'd0)
                                cur_rom = 7'd1;
                        end else begin
                            cur_ram = data[1:0];
                        end
                    end
                    default:
                    begin
                        cur_rom_mode = ~data[0];
                        if (cur_rom_mode)
                            cur_ram = 2'd0;
                    end
                endcase
            end
        end else if (addr >= 16'h4000 && addr < 16'h8000) begin
            res.target = TARGET_ROM;
            res.phys = {cur_rom, addr[13:0]};
        end else if (addr >= 16'hA000 && addr <= 16'hBFFF) begin
            res.target = TARGET_RAM;
            res.phys = {6'd0, cur_ram, addr[12:0]};
        end
        res.ram_en = cur_ram_en;
        res.rom = cur_rom;
        res.ram = cur_ram;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [20:0] exp_v,
                               input logic [20:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            beats_seen++;
            if (pending_translations.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual target %0h addr %0h",
                         $time, target, physical_address);
                err_count++;
            end else begin
                want = pending_translations.pop_front();
                check_field("target", 21'(want.target), 21'(target));
                check_field("physical_address", want.phys, physical_address);
                check_field("ram_enabled", 21'(want.ram_en), 21'(ram_enabled));
                check_field("rom_bank", 21'(want.rom), 21'(rom_bank));
                check_field("ram_bank", 21'(want.ram), 21'(ram_bank));
            end
        end
    end

    // result side: random stalls plus one long hold-off
    initial
    begin
        forever begin
            @(negedge clk);
            if (!hold_done && beats_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic idle_gap();
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_translations.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_cart_kind(input logic [1:0] kind);
        drain();
        cfg_wr_data <= kind;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_kind = kind;
    endtask

    task automatic send_access(input logic op, input logic [15:0] addr, input logic [7:0] data,
                               input logic typed, input translation_t typed_want);
        translation_t pred;
        operation <= op;
        bus_address <= addr;
        write_data <= data;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = translate_access(op, addr, data);
        pending_translations.push_back(typed ? typed_want : pred);
        @(negedge clk);
    endtask

    task automatic random_access(output logic op, output logic [15:0] addr,
                                 output logic [7:0] data);
        int pick;
        pick = $urandom_range(99);
        data = 8'($urandom_range(255));
        if (pick < 40) begin
            op = OP_WRITE;
            addr = 16'($urandom_range(16'h7FFF));
            if ($urandom_range(3) == 0)
                data[3:0] = RAM_ENABLE_KEY;
            if ($urandom_range(6) == 0)
                data[4:0] = 5'd0;
        end else if (pick < 75) begin
            op = OP_READ;
            if ($urandom_range(1) != 0)
                addr = 16'($urandom_range(16'h7FFF, 16'h4000));
            else
                addr = 16'($urandom_range(16'hBFFF, 16'hA000));
        end else begin
            op = 1'($urandom_range(1));
            addr = 16'($urandom_range(16'hFFFF));
        end
    endtask

    initial
    begin
        logic [1:0]  phase_kinds [NUM_PHASES];
        logic        op;
        logic [15:0] addr;
        logic [7:0]  data;

        directed_rows[0]  = '{CART_BANKED, OP_READ, 16'h4000, 8'h00, 1'b1,
                              '{TARGET_ROM, 21'h004000, 1'b0, 7'd1, 2'd0}};
        directed_rows[1]  = '{CART_BANKED, OP_READ, 16'h7FFF, 8'hFF, 1'b1,
                              '{TARGET_ROM, 21'h007FFF, 1'b0, 7'd1, 2'd0}};
        directed_rows[2]  = '{CART_BANKED, OP_READ, 16'hA000, 8'h00, 1'b1,
                              '{TARGET_RAM, 21'h000000, 1'b0, 7'd1, 2'd0}};
        directed_rows[3]  = '{CART_BANKED, OP_READ, 16'hBFFF, 8'h00, 1'b1,
                              '{TARGET_RAM, 21'h001FFF, 1'b0, 7'd1, 2'd0}};
        directed_rows[4]  = '{CART_BANKED, OP_READ, 16'h0000, 8'h00, 1'b1,
                              '{TARGET_NONE, 21'h000000, 1'b0, 7'd1, 2'd0}};
        directed_rows[5]  = '{CART_BANKED, OP_READ, 16'hFFFF, 8'hFF, 1'b1,
                              '{TARGET_NONE, 21'h000000, 1'b0, 7'd1, 2'd0}};
        directed_rows[6]  = '{CART_BANKED, OP_WRITE, 16'h0000, 8'h0A, 1'b1,
                              '{TARGET_NONE, 21'h000000, 1'b1, 7'd1, 2'd0}};
        directed_rows[7]  = '{CART_BANKED, OP_WRITE, 16'h1FFF, 8'h05, 1'b1,
                              '{TARGET_NONE, 21'h000000, 1'b0, 7'd1, 2'd0}};
        directed_rows[8]  = '{CART_BANKED, OP_WRITE, 16'h0000, 8'hFA, 1'b0, '0};
        directed_rows[9]  = '{CART_BANKED, OP_WRITE, 16'h2000, 8'h00, 1'b1,
                              '{TARGET_NONE, 21'h000000, 1'b1, 7'd1, 2'd0}};
        directed_rows[10] = '{CART_BANKED, OP_WRITE, 16'h3FFF, 8'hFF, 1'b1,
                              '{TARGET_NONE, 21'h000000, 1'b1, 7'h1F, 2'd0}};
        directed_rows[11] = '{CART_BANKED, OP_WRITE, 16'h4000, 8'hFF, 1'b1,
                              '{TARGET_NONE, 21'h000000, 1'b1, 7'h7F, 2'd0}};
        directed_rows[12] = '{CART_BANKED, OP_READ, 16'h7FFF, 8'h00, 1'b1,
                              '{TARGET_ROM, 21'h1FFFFF, 1'b1, 7'h7F, 2'd0}};
        directed_rows[13] = '{CART_BANKED, OP_WRITE, 16'h2000, 8'hE0, 1'b0, '0};
        directed_rows[14] = '{CART_BANKED, OP_WRITE, 16'h5FFF, 8'h00, 1'b0, '0};
        directed_rows[15] = '{CART_BANKED, OP_WRITE, 16'h6000, 8'h01, 1'b0, '0};
        directed_rows[16] = '{CART_BANKED, OP_WRITE, 16'h4000, 8'hFF, 1'b0, '0};
        directed_rows[17] = '{CART_BANKED, OP_READ, 16'hBFFF, 8'h00, 1'b0, '0};
        directed_rows[18] = '{CART_BANKED, OP_WRITE, 16'h7FFF, 8'hFE, 1'b0, '0};
        directed_rows[19] = '{CART_BANKED, OP_WRITE, 16'h0000, 8'h0B, 1'b0, '0};
        directed_rows[20] = '{CART_BANKED, OP_WRITE, 16'h8000, 8'hFF, 1'b0, '0};
        directed_rows[21] = '{CART_BANKED, OP_READ, 16'hA123, 8'h00, 1'b0, '0};
        directed_rows[22] = '{CART_ROM_ONLY, OP_WRITE, 16'h2000, 8'h05, 1'b0, '0};
        directed_rows[23] = '{CART_ROM_ONLY, OP_READ, 16'h4000, 8'h00, 1'b0, '0};
        directed_rows[24] = '{CART_KIND_RESERVED, OP_WRITE, 16'h0000, 8'h0A, 1'b0, '0};
        directed_rows[25] = '{CART_UNSUPPORTED, OP_WRITE, 16'h4000, 8'hFF, 1'b0, '0};

        phase_kinds = '{CART_BANKED, CART_ROM_ONLY, CART_BANKED, CART_UNSUPPORTED,
                        CART_BANKED, CART_KIND_RESERVED, CART_BANKED, CART_BANKED};

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (directed_rows[i].kind != cur_kind)
                set_cart_kind(directed_rows[i].kind);
            idle_gap();
            send_access(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                        directed_rows[i].typed, directed_rows[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_cart_kind(phase_kinds[p]);
            calm = (p == CALM_PHASE);
            for (int n = 0; n < ACCESSES_PER_PHASE; n++) begin
                if (p == DRAIN_PHASE && n == DRAIN_AT)
                    drain();
                idle_gap();
                random_access(op, addr, data);
                send_access(op, addr, data, 1'b0, '0);
            end
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        while (pending_translations.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
